/* rtl/sra_pkg.sv */
package sra_pkg;

	localparam int SEQ_BITS = 4;
	localparam int SLOT_BITS = 3;
	localparam int PAY_BITS = 64;
	localparam int BUF_COUNT = 8;
	localparam logic [SEQ_BITS-1:0] MAX_SEQ = 4'd15;

	typedef enum logic [2:0] {
		CMD_NEW_PKT  = 3'd0,
		CMD_ARRIVED  = 3'd1,
		CMD_DATA_TO  = 3'd2,
		CMD_ACK_TO   = 3'd3,
		CMD_CKSUM    = 3'd4
	} cmd_code_t;

	typedef enum logic [1:0] {
		FR_DATA = 2'd0,
		FR_ACK  = 2'd1,
		FR_NAK  = 2'd2,
		FR_BAD  = 2'd3
	} frame_kind_t;

	typedef enum logic [2:0] {
		ACT_SEND_DATA = 3'd0,
		ACT_SEND_ACK  = 3'd1,
		ACT_SEND_NAK  = 3'd2,
		ACT_DELIVER   = 3'd3,
		ACT_STOP_TMR  = 3'd4,
		ACT_START_ACK = 3'd5,
		ACT_STATUS    = 3'd6
	} action_t;

	typedef struct packed {
		logic [2:0]          cmd;
		logic [1:0]          frame_type;
		logic [SEQ_BITS-1:0] frame_seq;
		logic [SEQ_BITS-1:0] frame_ack_num;
		logic                crc_good;
		logic [PAY_BITS-1:0] payload_in;
		logic [SEQ_BITS-1:0] timeout_seq;
	} in_item_t;

	typedef struct packed {
		logic [2:0]           action;
		logic [SEQ_BITS-1:0]  out_seq;
		logic [SEQ_BITS-1:0]  out_ack;
		logic [PAY_BITS-1:0]  out_payload;
		logic [SLOT_BITS-1:0] timer_slot;
		logic                 accept_more;
		logic                 last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DATA_FRAME,
		ST_DELIV_RD,
		ST_DELIV_EMIT,
		ST_DELIV_END,
		ST_NAK_RD,
		ST_NAK_EMIT,
		ST_STOP_LOOP,
		ST_TO_RD,
		ST_TO_EMIT,
		ST_STATUS
	} state_t;

	function automatic logic in_window(logic [SEQ_BITS-1:0] a, logic [SEQ_BITS-1:0] b,
			logic [SEQ_BITS-1:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

endpackage

/* rtl/sra_ram.sv */
module sra_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/selective_repeat_arq.sv */
// Each accepted item yields a run of results that ends with a status result; every delivery
// first reads its slot of the receive payload RAM (ST_DELIV_RD) and is emitted after that read.
// Throughput: one item at a time, since in_stall holds off a new item until its run is done;
// the longest run has nineteen results (eight deliveries and eight releases).
// Reset: arst_n clears window edges low/next/exp, counters and arrival bitmap, sets upper
// to BUF_COUNT and sets the NAK permit; payload RAMs are not cleared.
module selective_repeat_arq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sra_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sra_pkg::out_item_t   out_item
);

	localparam int SB = sra_pkg::SEQ_BITS;
	localparam int LB = sra_pkg::SLOT_BITS;

	sra_pkg::state_t state_q, state_d;
	sra_pkg::in_item_t item_q;
	logic item_ld;

	logic [SB-1:0] low_q, low_d, next_q, next_d, exp_q, exp_d, upper_q, upper_d, outst_q, outst_d;
	logic [SB-1:0] rseq_q, rseq_d;
	logic [sra_pkg::BUF_COUNT-1:0] map_q, map_d;
	logic nak_ok_q, nak_ok_d;

	// output register
	sra_pkg::out_item_t res;
	logic res_vld;
	logic ovalid_q;
	sra_pkg::out_item_t oitem_q;
	logic ofree;

	// memories
	logic snd_we, rcv_we;
	logic [LB-1:0] snd_wa, rcv_wa, snd_ra, rcv_ra;
	logic [sra_pkg::PAY_BITS-1:0] snd_rd, rcv_rd;

	sra_ram #(.DEPTH(sra_pkg::BUF_COUNT), .WIDTH(sra_pkg::PAY_BITS)) u_snd (
		.clk(clk), .we(snd_we), .waddr(snd_wa), .wdata(item_q.payload_in),
		.raddr(snd_ra), .rdata(snd_rd));
	sra_ram #(.DEPTH(sra_pkg::BUF_COUNT), .WIDTH(sra_pkg::PAY_BITS)) u_rcv (
		.clk(clk), .we(rcv_we), .waddr(rcv_wa), .wdata(item_q.payload_in),
		.raddr(rcv_ra), .rdata(rcv_rd));

	assign ofree = !ovalid_q || !out_stall;
	assign in_stall = (state_q != sra_pkg::ST_IDLE);
	assign item_ld = in_valid && !in_stall;
	assign out_valid = ovalid_q;
	assign out_item = oitem_q;

	function automatic logic [SB-1:0] inc(logic [SB-1:0] s);
		return s + SB'(1);
	endfunction

	always_comb begin
		logic [SB-1:0] ackv;
		logic [LB-1:0] fslot;
		ackv = exp_q - SB'(1);
		fslot = item_q.frame_seq[LB-1:0];
		state_d = state_q;
		low_d = low_q; next_d = next_q; exp_d = exp_q; upper_d = upper_q;
		outst_d = outst_q; map_d = map_q; nak_ok_d = nak_ok_q; rseq_d = rseq_q;
		res = '0; res_vld = 1'b0;
		snd_we = 1'b0; rcv_we = 1'b0;
		snd_wa = next_q[LB-1:0]; rcv_wa = fslot;
		snd_ra = rseq_q[LB-1:0]; rcv_ra = exp_q[LB-1:0];
		case (state_q)
			sra_pkg::ST_IDLE: begin
				if (item_ld) state_d = sra_pkg::ST_DISPATCH;
			end
			sra_pkg::ST_DISPATCH: begin
				case (item_q.cmd)
					sra_pkg::CMD_NEW_PKT: begin
						if (outst_q < SB'(sra_pkg::BUF_COUNT)) begin
							// write now, read same slot next cycle
							snd_we = 1'b1;
							rseq_d = next_q;
							outst_d = outst_q + SB'(1);
							next_d = inc(next_q);
							state_d = sra_pkg::ST_TO_RD;
						end else state_d = sra_pkg::ST_STATUS;
					end
					sra_pkg::CMD_ARRIVED: begin
						if (!item_q.crc_good) begin
							if (nak_ok_q) begin
								if (ofree) begin
									res_vld = 1'b1;
									res.action = sra_pkg::ACT_SEND_NAK;
									res.out_ack = ackv;
									nak_ok_d = 1'b0;
									state_d = sra_pkg::ST_STATUS;
								end
							end else state_d = sra_pkg::ST_STATUS;
						end else if (item_q.frame_type == sra_pkg::FR_DATA)
							state_d = sra_pkg::ST_DATA_FRAME;
						else if (item_q.frame_type == sra_pkg::FR_NAK) begin
							rseq_d = item_q.frame_ack_num + SB'(1);
							state_d = sra_pkg::ST_NAK_RD;
						end else if (item_q.frame_type == sra_pkg::FR_ACK)
							state_d = sra_pkg::ST_STOP_LOOP;
						else state_d = sra_pkg::ST_STATUS;
					end
					sra_pkg::CMD_DATA_TO: begin
						rseq_d = item_q.timeout_seq;
						if (sra_pkg::in_window(low_q, item_q.timeout_seq, next_q))
							state_d = sra_pkg::ST_TO_RD;
						else state_d = sra_pkg::ST_STATUS;
					end
					sra_pkg::CMD_ACK_TO: begin
						if (ofree) begin
							res_vld = 1'b1;
							res.action = sra_pkg::ACT_SEND_ACK;
							res.out_ack = ackv;
							state_d = sra_pkg::ST_STATUS;
						end
					end
					sra_pkg::CMD_CKSUM: begin
						if (nak_ok_q) begin
							if (ofree) begin
								res_vld = 1'b1;
								res.action = sra_pkg::ACT_SEND_NAK;
								res.out_ack = ackv;
								nak_ok_d = 1'b0;
								state_d = sra_pkg::ST_STATUS;
							end
						end else state_d = sra_pkg::ST_STATUS;
					end
					default: state_d = sra_pkg::ST_STATUS;
				endcase
			end
			sra_pkg::ST_DATA_FRAME: begin
				if (ofree) begin
					res_vld = 1'b1;
					if (item_q.frame_seq != exp_q && nak_ok_q) begin
						res.action = sra_pkg::ACT_SEND_NAK;
						res.out_ack = ackv;
						nak_ok_d = 1'b0;
					end else res.action = sra_pkg::ACT_START_ACK;
					if (sra_pkg::in_window(exp_q, item_q.frame_seq, upper_q) && !map_q[fslot]) begin
						map_d[fslot] = 1'b1;
						rcv_we = 1'b1;
						state_d = sra_pkg::ST_DELIV_RD;
					end else state_d = sra_pkg::ST_STOP_LOOP;
				end
			end
			sra_pkg::ST_DELIV_RD: begin
				// slot of exp_q is read this cycle; write above settled last cycle.
				// The new frame still inside the window means nothing was delivered.
				if (map_q[exp_q[LB-1:0]]) state_d = sra_pkg::ST_DELIV_EMIT;
				else if (sra_pkg::in_window(exp_q, item_q.frame_seq, upper_q))
					state_d = sra_pkg::ST_STOP_LOOP;
				else state_d = sra_pkg::ST_DELIV_END;
			end
			sra_pkg::ST_DELIV_EMIT: begin
				if (ofree) begin
					res_vld = 1'b1;
					res.action = sra_pkg::ACT_DELIVER;
					res.out_seq = exp_q;
					res.out_payload = rcv_rd;
					nak_ok_d = 1'b1;
					map_d[exp_q[LB-1:0]] = 1'b0;
					exp_d = inc(exp_q);
					upper_d = inc(upper_q);
					state_d = sra_pkg::ST_DELIV_RD;
				end else rcv_ra = exp_q[LB-1:0];
			end
			sra_pkg::ST_DELIV_END: begin
				// at least one delivery happened: close the run with the ack timer
				if (ofree) begin
					res_vld = 1'b1;
					res.action = sra_pkg::ACT_START_ACK;
					state_d = sra_pkg::ST_STOP_LOOP;
				end
			end
			sra_pkg::ST_NAK_RD: begin
				if (sra_pkg::in_window(low_q, rseq_q, next_q)) state_d = sra_pkg::ST_NAK_EMIT;
				else state_d = sra_pkg::ST_STOP_LOOP;
			end
			sra_pkg::ST_NAK_EMIT, sra_pkg::ST_TO_EMIT: begin
				if (ofree) begin
					res_vld = 1'b1;
					res.action = sra_pkg::ACT_SEND_DATA;
					res.out_seq = rseq_q;
					res.out_ack = ackv;
					res.out_payload = snd_rd;
					res.timer_slot = rseq_q[LB-1:0];
					state_d = (state_q == sra_pkg::ST_NAK_EMIT) ? sra_pkg::ST_STOP_LOOP
						: sra_pkg::ST_STATUS;
				end
			end
			sra_pkg::ST_TO_RD: state_d = sra_pkg::ST_TO_EMIT;
			sra_pkg::ST_STOP_LOOP: begin
				if (outst_q != '0 && sra_pkg::in_window(low_q, item_q.frame_ack_num, next_q)) begin
					if (ofree) begin
						res_vld = 1'b1;
						res.action = sra_pkg::ACT_STOP_TMR;
						res.out_seq = low_q;
						res.timer_slot = low_q[LB-1:0];
						outst_d = outst_q - SB'(1);
						low_d = inc(low_q);
					end
				end else state_d = sra_pkg::ST_STATUS;
			end
			sra_pkg::ST_STATUS: begin
				if (ofree) begin
					res_vld = 1'b1;
					res.action = sra_pkg::ACT_STATUS;
					res.accept_more = (outst_q < SB'(sra_pkg::BUF_COUNT));
					res.last = 1'b1;
					state_d = sra_pkg::ST_IDLE;
				end
			end
			default: state_d = sra_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sra_pkg::ST_IDLE;
			low_q <= '0; next_q <= '0; exp_q <= '0;
			upper_q <= SB'(sra_pkg::BUF_COUNT);
			outst_q <= '0; map_q <= '0; nak_ok_q <= 1'b1;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			low_q <= low_d; next_q <= next_d; exp_q <= exp_d; upper_q <= upper_d;
			outst_q <= outst_d; map_q <= map_d; nak_ok_q <= nak_ok_d;
			if (res_vld) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rseq_q <= rseq_d;
		if (item_ld) item_q <= in_item;
		if (res_vld) oitem_q <= res;
	end

`ifndef NO_ASSERTIONS
	a_outst_max: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= SB'(sra_pkg::BUF_COUNT)) else $error("outstanding overflow");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && out_stall |-> !res_vld) else $error("result overwritten");
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q - low_q) == outst_q) else $error("send window mismatch");
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(upper_q - exp_q) == SB'(sra_pkg::BUF_COUNT)) else $error("recv window mismatch");
`endif

endmodule

/* sim/selective_repeat_arq_tb.sv */
`timescale 1ns / 1ps

module selective_repeat_arq_tb;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int N_RANDOM = 385;
	localparam int SQB = sra_pkg::SEQ_BITS;
	localparam int SLB = sra_pkg::SLOT_BITS;
	localparam int PYB = sra_pkg::PAY_BITS;
	localparam int NBUF = sra_pkg::BUF_COUNT;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	sra_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_stall;
	sra_pkg::out_item_t out_item;

	selective_repeat_arq uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	// Mirror of the link endpoint state
	logic [SQB-1:0] tx_low, tx_next, rx_expected, rx_upper;
	int             tx_pending;
	logic [PYB-1:0] tx_store [NBUF];
	logic [PYB-1:0] rx_store [NBUF];
	logic           rx_arrived [NBUF];
	logic           nak_permit;

	sra_pkg::out_item_t action_q [$];
	int        mismatches;
	int        idle_cycles;
	logic      calm;

	typedef struct {
		sra_pkg::in_item_t  item;
		int                 n_typed;
		sra_pkg::out_item_t t0;
		sra_pkg::out_item_t t1;
	} row_t;

	row_t rows [$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic seq_between(logic [SQB-1:0] a, logic [SQB-1:0] b,
			logic [SQB-1:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

	function automatic sra_pkg::out_item_t mk_act(sra_pkg::action_t act, logic [SQB-1:0] seq,
			logic [SQB-1:0] ack, logic [PYB-1:0] pay, logic [SLB-1:0] slot,
			logic acc, logic fin);
		sra_pkg::out_item_t o;
		o.action = act;
		o.out_seq = seq;
		o.out_ack = ack;
		o.out_payload = pay;
		o.timer_slot = slot;
		o.accept_more = acc;
		o.last = fin;
		return o;
	endfunction

	function automatic sra_pkg::in_item_t mk_event(logic [2:0] cmd, logic [1:0] kind,
			logic [SQB-1:0] seq, logic [SQB-1:0] ack, logic crc,
			logic [PYB-1:0] pay, logic [SQB-1:0] to_seq);
		sra_pkg::in_item_t it;
		it.cmd = cmd;
		it.frame_type = kind;
		it.frame_seq = seq;
		it.frame_ack_num = ack;
		it.crc_good = crc;
		it.payload_in = pay;
		it.timeout_seq = to_seq;
		return it;
	endfunction

	function automatic logic [SQB-1:0] piggy_ack();
		return rx_expected - 1'b1;
	endfunction

	function automatic void queue_send(logic [SQB-1:0] seq);
		logic [SLB-1:0] slot;
		slot = seq[SLB-1:0];
		action_q.push_back(mk_act(sra_pkg::ACT_SEND_DATA, seq, piggy_ack(), tx_store[slot],
			slot, 0, 0));
	endfunction

	function automatic void queue_nak();
		action_q.push_back(mk_act(sra_pkg::ACT_SEND_NAK, 0, piggy_ack(), 0, 0, 0, 0));
		nak_permit = 1'b0;
	endfunction

	// Work out the run of actions one event causes and advance the mirror
	function automatic void predict_actions(sra_pkg::in_item_t it);
		logic [SLB-1:0] slot;
		logic [SQB-1:0] resend;
		logic           delivered;
		case (it.cmd)
			sra_pkg::CMD_NEW_PKT: begin
				if (tx_pending < NBUF) begin
					tx_pending++;
					tx_store[tx_next[SLB-1:0]] = it.payload_in;
					queue_send(tx_next);
					tx_next = tx_next + 1'b1;
				end
			end
			sra_pkg::CMD_ARRIVED: begin
				if (!it.crc_good) begin
					if (nak_permit)
						queue_nak();
				end else if (it.frame_type != sra_pkg::FR_BAD) begin
					if (it.frame_type == sra_pkg::FR_DATA) begin
						slot = it.frame_seq[SLB-1:0];
						if (it.frame_seq != rx_expected && nak_permit)
							queue_nak();
						else
							action_q.push_back(mk_act(sra_pkg::ACT_START_ACK, 0, 0, 0, 0,
								0, 0));
						if (seq_between(rx_expected, it.frame_seq, rx_upper) &&
								!rx_arrived[slot]) begin
							delivered = 1'b0;
							rx_arrived[slot] = 1'b1;
							rx_store[slot] = it.payload_in;
							for (int g = 0; g < NBUF; g++) begin
								if (!rx_arrived[rx_expected[SLB-1:0]])
									break;
								action_q.push_back(mk_act(sra_pkg::ACT_DELIVER, rx_expected, 0,
									rx_store[rx_expected[SLB-1:0]], 0, 0, 0));
								nak_permit = 1'b1;
								rx_arrived[rx_expected[SLB-1:0]] = 1'b0;
								rx_expected = rx_expected + 1'b1;
								rx_upper = rx_upper + 1'b1;
								delivered = 1'b1;
							end
							if (delivered)
								action_q.push_back(mk_act(sra_pkg::ACT_START_ACK, 0, 0, 0, 0,
									0, 0));
						end
					end
					if (it.frame_type == sra_pkg::FR_NAK) begin
						resend = it.frame_ack_num + 1'b1;
						if (seq_between(tx_low, resend, tx_next))
							queue_send(resend);
					end
					// Release every frame the piggybacked ack covers
					for (int g = 0; g < NBUF; g++) begin
						if (!(tx_pending > 0 && seq_between(tx_low, it.frame_ack_num, tx_next)))
							break;
						tx_pending--;
						action_q.push_back(mk_act(sra_pkg::ACT_STOP_TMR, tx_low, 0, 0,
							tx_low[SLB-1:0], 0, 0));
						tx_low = tx_low + 1'b1;
					end
				end
			end
			sra_pkg::CMD_DATA_TO: begin
				if (seq_between(tx_low, it.timeout_seq, tx_next))
					queue_send(it.timeout_seq);
			end
			sra_pkg::CMD_ACK_TO:
				action_q.push_back(mk_act(sra_pkg::ACT_SEND_ACK, 0, piggy_ack(), 0, 0, 0, 0));
			sra_pkg::CMD_CKSUM: begin
				if (nak_permit)
					queue_nak();
			end
			default: ;
		endcase
		action_q.push_back(mk_act(sra_pkg::ACT_STATUS, 0, 0, 0, 0, tx_pending < NBUF, 1));
	endfunction

	// Offer one item after a gap; predict on acceptance, or take the typed actions
	task automatic offer_item(sra_pkg::in_item_t it, int gap, int n_typed,
			sra_pkg::out_item_t t0, sra_pkg::out_item_t t1);
		int base;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		base = action_q.size();
		predict_actions(it);
		if (n_typed > 0) begin
			while (action_q.size() > base) void'(action_q.pop_back());
			action_q.push_back(t0);
			if (n_typed > 1)
				action_q.push_back(t1);
		end
	endtask

	function automatic sra_pkg::in_item_t random_event();
		sra_pkg::in_item_t it;
		int pick;
		it = mk_event(sra_pkg::CMD_NEW_PKT, sra_pkg::FR_DATA, 0, 0, 1'b1,
			{$urandom, $urandom}, 0);
		it.frame_seq = 4'($urandom_range(0, 15));
		it.frame_ack_num = 4'($urandom_range(0, 15));
		it.timeout_seq = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// noise: any field value at all
			it.cmd = 3'($urandom_range(0, 7));
			it.frame_type = 2'($urandom_range(0, 3));
			it.crc_good = 1'($urandom_range(0, 1));
		end else if (pick < 38) begin
			it.cmd = sra_pkg::CMD_NEW_PKT;
		end else if (pick < 63) begin
			it.cmd = sra_pkg::CMD_ARRIVED;
			it.frame_type = sra_pkg::FR_DATA;
			it.frame_seq = rx_expected + 4'($urandom_range(0, 9));
			it.frame_ack_num = tx_low + 4'($urandom_range(0, 9)) - 1'b1;
			it.crc_good = ($urandom_range(0, 9) != 0);
		end else if (pick < 75) begin
			it.cmd = sra_pkg::CMD_ARRIVED;
			it.frame_type = sra_pkg::FR_ACK;
			it.frame_ack_num = tx_low + 4'($urandom_range(0, 9)) - 1'b1;
			it.crc_good = ($urandom_range(0, 9) != 0);
		end else if (pick < 83) begin
			it.cmd = sra_pkg::CMD_ARRIVED;
			it.frame_type = sra_pkg::FR_NAK;
			it.frame_ack_num = tx_low + 4'($urandom_range(0, 9)) - 1'b1;
		end else if (pick < 93) begin
			it.cmd = sra_pkg::CMD_DATA_TO;
			it.timeout_seq = tx_low + 4'($urandom_range(0, 9));
		end else if (pick < 97) begin
			it.cmd = sra_pkg::CMD_ACK_TO;
		end else begin
			it.cmd = sra_pkg::CMD_CKSUM;
		end
		return it;
	endfunction

	task automatic drain_actions();
		while (action_q.size() != 0) @(posedge clk);
	endtask

	// Result side: draw a stall per item, then wait for it to be taken
	initial begin
		int n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 14);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Compare each taken result with the oldest expected action
	always @(posedge clk) begin
		sra_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (action_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: got %h", out_item);
			end else begin
				want = action_q.pop_front();
				if (out_item.action !== want.action || out_item.out_seq !== want.out_seq ||
						out_item.out_ack !== want.out_ack ||
						out_item.out_payload !== want.out_payload ||
						out_item.timer_slot !== want.timer_slot ||
						out_item.accept_more !== want.accept_more ||
						out_item.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: act %0d/%0d seq %0d/%0d ack %0d/%0d pay %h/%h",
							" slot %0d/%0d acc %0d/%0d last %0d/%0d"},
							want.action, out_item.action, want.out_seq, out_item.out_seq,
							want.out_ack, out_item.out_ack, want.out_payload, out_item.out_payload,
							want.timer_slot, out_item.timer_slot, want.accept_more,
							out_item.accept_more, want.last, out_item.last);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void add_row(sra_pkg::in_item_t it, int n_typed,
			sra_pkg::out_item_t t0, sra_pkg::out_item_t t1);
		row_t r;
		r.item = it;
		r.n_typed = n_typed;
		r.t0 = t0;
		r.t1 = t1;
		rows.push_back(r);
	endfunction

	initial begin
		sra_pkg::out_item_t st_open, st_full, none;
		int gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		mismatches = 0;
		idle_cycles = 0;
		calm = 1'b0;
		tx_low = '0;
		tx_next = '0;
		rx_expected = '0;
		rx_upper = 4'(NBUF);
		tx_pending = 0;
		nak_permit = 1'b1;
		for (int i = 0; i < NBUF; i++) begin
			rx_arrived[i] = 1'b0;
			tx_store[i] = '0;
			rx_store[i] = '0;
		end
		none = '0;
		st_open = mk_act(sra_pkg::ACT_STATUS, 0, 0, 0, 0, 1, 1);
		st_full = mk_act(sra_pkg::ACT_STATUS, 0, 0, 0, 0, 0, 1);

		// Directed events: fresh link, error codes, a full window, then recovery
		add_row(mk_event(sra_pkg::CMD_ACK_TO, sra_pkg::FR_DATA, 0, 0, 1, 0, 0), 2,
			mk_act(sra_pkg::ACT_SEND_ACK, 0, 4'hf, 0, 0, 0, 0), st_open);
		add_row(mk_event(sra_pkg::CMD_CKSUM, sra_pkg::FR_DATA, 0, 0, 1, 0, 0), 2,
			mk_act(sra_pkg::ACT_SEND_NAK, 0, 4'hf, 0, 0, 0, 0), st_open);
		add_row(mk_event(sra_pkg::CMD_CKSUM, sra_pkg::FR_DATA, 0, 0, 1, 0, 0), 1,
			st_open, none);
		add_row(mk_event(CMD_UNUSED, sra_pkg::FR_BAD, 4'hf, 4'hf, 1, '1, 4'hf), 1,
			st_open, none);
		add_row(mk_event(sra_pkg::CMD_NEW_PKT, sra_pkg::FR_DATA, 0, 0, 1, '1, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_NEW_PKT, sra_pkg::FR_DATA, 0, 0, 0, '0, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_NEW_PKT, sra_pkg::FR_DATA, 0, 0, 1, {32{2'b01}}, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_NEW_PKT, sra_pkg::FR_DATA, 0, 0, 1, {32{2'b10}}, 0), 0,
			none, none);
		for (int i = 0; i < 4; i++)
			add_row(mk_event(sra_pkg::CMD_NEW_PKT, sra_pkg::FR_DATA, 0, 0, 1,
				{$urandom, $urandom}, 0), 0, none, none);
		add_row(mk_event(sra_pkg::CMD_NEW_PKT, sra_pkg::FR_DATA, 0, 0, 1, '1, 0), 1,
			st_full, none);
		add_row(mk_event(sra_pkg::CMD_DATA_TO, sra_pkg::FR_DATA, 0, 0, 1, 0, 4'd3), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_DATA_TO, sra_pkg::FR_DATA, 0, 0, 1, 0, 4'd12), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_NAK, 0, 4'd2, 1, 0, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_DATA, 4'd1, 4'd15, 1, '1, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_DATA, 4'd0, 4'd15, 1,
			64'h0123_4567_89ab_cdef, 0), 0, none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_BAD, 4'd2, 4'd7, 1, 0, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_ACK, 4'd2, 4'd7, 0, 0, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_DATA, 4'd5, 4'd15, 1, '1, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_ACK, 0, 4'd7, 1, 0, 0), 0,
			none, none);
		add_row(mk_event(sra_pkg::CMD_ARRIVED, sra_pkg::FR_DATA, 4'd15, 4'd15, 1, 0, 0), 0,
			none, none);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			gap = $urandom_range(0, 14);
			offer_item(rows[i].item, gap, rows[i].n_typed, rows[i].t0, rows[i].t1);
		end

		// hold the sender until every expected action has come
		in_valid <= 1'b0;
		drain_actions();

		for (int i = 0; i < N_RANDOM; i++) begin
			calm = ((i / 40) % 3) == 1;
			gap = calm ? 0 : $urandom_range(0, 14);
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				drain_actions();
				gap = 1;
			end
			offer_item(random_event(), gap, 0, none, none);
		end
		in_valid <= 1'b0;
		calm = 1'b0;

		drain_actions();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && action_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
